>>> hw/rtl/alt_pkg.sv
// shared types and codes for the array list table
// no dependencies
`default_nettype none
package alt_pkg;
  localparam int Depth = 16;
  localparam int IdxW = 4;
  localparam int LenW = 5;

  typedef enum logic [2:0] {
    KIND_APPEND = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_DELETE = 3'd2,
    KIND_GET    = 3'd3,
    KIND_SET    = 3'd4,
    KIND_SORTED = 3'd5,
    KIND_SEARCH = 3'd6,
    KIND_NOP    = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_RANGE     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_op_t;

  typedef enum logic [1:0] {
    FSM_IDLE   = 2'd0,
    FSM_SEARCH = 2'd1,
    FSM_STATS  = 2'd2
  } fsm_t;
endpackage
`default_nettype wire

>>> hw/rtl/alt_cell.sv
// one list entry of the cell row, with its neighbor moves and compare
// depends on alt_pkg
`default_nettype none
module alt_cell (
  input  wire logic             clk,
  input  wire alt_pkg::cell_op_t op,
  input  wire logic [31:0]      left,
  input  wire logic [31:0]      right,
  input  wire logic [31:0]      x,
  input  wire logic             beyond,
  input  wire logic             sfx_in,
  output logic      [31:0]      entry_r,
  output logic                  sfx_out
);
  logic [31:0] entry_nxt;
  logic        lt;

  assign lt = $signed(x) < $signed(entry_r);
  // all cells from here up to the list end hold words above the key
  assign sfx_out = beyond | (lt & sfx_in);

  always_comb begin
    unique case (op)
      alt_pkg::CELL_HOLD:  entry_nxt = entry_r;
      alt_pkg::CELL_LOAD:  entry_nxt = x;
      alt_pkg::CELL_LEFT:  entry_nxt = left;
      alt_pkg::CELL_RIGHT: entry_nxt = right;
      default:             entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end
endmodule
`default_nettype wire

>>> hw/rtl/array_list_table_unit.sv
// top level of the array list table: control, search, statistics sweep
// depends on alt_pkg and alt_cell
`default_nettype none
// A bounded list of up to 16 signed words held in a row of cells. One
// operation is taken per input transfer and one result transfer comes out.
// Append, insert, delete, get, set and sorted insert finish their move in
// the cell row in the accept cycle; binary search then walks its midpoint
// path, one probe per cycle (up to 5 probes, a miss is then settled in the
// search state). Every operation ends with a statistics sweep over the
// current entries, one entry per cycle. A new item is taken while an
// earlier result still waits in the output register.
module array_list_table_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [2:0]   in_tuser,   // kind
  input  wire logic [39:0]  in_tdata,   // position[4:0], value[36:5], zero pad
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status, read_value, found_index, entry_count, total, largest, smallest
  output logic      [143:0] out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [4:0]   cfg_data
);
  localparam int D = alt_pkg::Depth;

  alt_pkg::fsm_t state_r, state_nxt;
  logic [4:0]  cap_r;
  logic [4:0]  len_r;
  logic [31:0] x_r;
  logic [1:0]  status_r;
  logic [31:0] rd_r;
  logic [3:0]  fidx_r;
  logic signed [5:0] lo_r, hi_r;
  logic [4:0]  idx_r;
  logic signed [35:0] sum_r;
  logic [31:0] mx_r, mn_r;
  logic        out_valid_r;
  logic [143:0] out_data_r;

  logic [31:0] ent [D];
  logic [D-1:0] sfx;
  alt_pkg::cell_op_t cop [D];

  logic        acc;
  alt_pkg::kind_t kind;
  logic [4:0]  pos;
  logic [31:0] xin;
  logic [4:0]  cap;
  logic        full;
  logic        pos_ok;
  logic signed [6:0] lh_sum;
  logic [3:0]  mid;
  logic [3:0]  rd_idx;
  logic [31:0] rd_word;
  logic        sweep_more;
  logic        emit;

  assign acc = in_tvalid & in_tready;
  assign kind = alt_pkg::kind_t'(in_tuser);
  assign pos = in_tdata[4:0];
  assign xin = in_tdata[36:5];
  assign cap = (cap_r > 5'(D)) ? 5'(D) : cap_r;
  assign full = len_r >= cap;
  assign pos_ok = pos < len_r;
  assign lh_sum = 7'(lo_r) + 7'(hi_r);
  assign mid = lh_sum[4:1];
  assign sweep_more = idx_r < len_r;
  assign emit = (state_r == alt_pkg::FSM_STATS) && !sweep_more &&
                (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  always_comb begin
    unique case (state_r)
      alt_pkg::FSM_SEARCH: rd_idx = mid;
      alt_pkg::FSM_STATS:  rd_idx = idx_r[3:0];
      default:             rd_idx = pos[3:0];
    endcase
  end
  assign rd_word = ent[rd_idx];

  // cell row
  for (genvar i = 0; i < D; i++) begin : g_cell
    logic [31:0] lft, rgt;
    logic        sin;
    logic        take_left;
    assign lft = (i == 0) ? 32'd0 : ent[(i == 0) ? 0 : i-1];
    assign rgt = (i == D-1) ? 32'd0 : ent[(i == D-1) ? i : i+1];
    assign sin = (i == D-1) ? 1'b1 : sfx[(i == D-1) ? i : i+1];
    assign take_left = (i != 0) && (5'(i) <= len_r) && sfx[(i == 0) ? 0 : i-1];

    always_comb begin
      cop[i] = alt_pkg::CELL_HOLD;
      if (acc) begin
        unique case (kind)
          alt_pkg::KIND_APPEND:
            if (!full && 5'(i) == len_r) cop[i] = alt_pkg::CELL_LOAD;
          alt_pkg::KIND_INSERT:
            if (pos <= len_r && !full) begin
              if (5'(i) == pos) cop[i] = alt_pkg::CELL_LOAD;
              else if (5'(i) > pos && 5'(i) <= len_r) cop[i] = alt_pkg::CELL_LEFT;
            end
          alt_pkg::KIND_DELETE:
            if (pos_ok && 5'(i) >= pos && 6'(i) + 6'd1 < 6'(len_r))
              cop[i] = alt_pkg::CELL_RIGHT;
          alt_pkg::KIND_SET:
            if (pos_ok && 5'(i) == pos) cop[i] = alt_pkg::CELL_LOAD;
          alt_pkg::KIND_SORTED:
            if (!full) begin
              if (take_left) cop[i] = alt_pkg::CELL_LEFT;
              else if (sfx[i]) cop[i] = alt_pkg::CELL_LOAD;
            end
          default: cop[i] = alt_pkg::CELL_HOLD;
        endcase
      end
    end

    alt_cell u_cell (
      .clk     (clk),
      .op      (cop[i]),
      .left    (lft),
      .right   (rgt),
      .x       (xin),
      .beyond  (5'(i) >= len_r),
      .sfx_in  (sin),
      .entry_r (ent[i]),
      .sfx_out (sfx[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      alt_pkg::FSM_IDLE:
        if (acc) state_nxt = (kind == alt_pkg::KIND_SEARCH) ? alt_pkg::FSM_SEARCH
                                                            : alt_pkg::FSM_STATS;
      alt_pkg::FSM_SEARCH:
        if (lo_r > hi_r || x_r == rd_word) state_nxt = alt_pkg::FSM_STATS;
      alt_pkg::FSM_STATS:
        if (emit) state_nxt = alt_pkg::FSM_IDLE;
      default: state_nxt = alt_pkg::FSM_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready = (state_r == alt_pkg::FSM_IDLE);
    out_tvalid = out_valid_r;
    out_tdata = out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= alt_pkg::FSM_IDLE;
      cap_r <= 5'd16;
      len_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) cap_r <= cfg_data;
      if (acc) begin
        unique case (kind)
          alt_pkg::KIND_APPEND, alt_pkg::KIND_SORTED:
            if (!full) len_r <= len_r + 5'd1;
          alt_pkg::KIND_INSERT:
            if (pos <= len_r && !full) len_r <= len_r + 5'd1;
          alt_pkg::KIND_DELETE:
            if (pos_ok) len_r <= len_r - 5'd1;
          default: len_r <= len_r;
        endcase
      end
      if (emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (acc) begin
      x_r <= xin;
      rd_r <= '0;
      fidx_r <= '0;
      status_r <= alt_pkg::ST_DONE;
      lo_r <= '0;
      hi_r <= 6'(len_r) - 6'sd1;
      idx_r <= '0;
      sum_r <= '0;
      mx_r <= '0;
      mn_r <= '0;
      unique case (kind)
        alt_pkg::KIND_APPEND, alt_pkg::KIND_SORTED:
          if (full) status_r <= alt_pkg::ST_FULL;
        alt_pkg::KIND_INSERT:
          if (pos > len_r) status_r <= alt_pkg::ST_RANGE;
          else if (full) status_r <= alt_pkg::ST_FULL;
        alt_pkg::KIND_DELETE:
          if (pos_ok) rd_r <= rd_word;
          else status_r <= alt_pkg::ST_RANGE;
        alt_pkg::KIND_GET:
          if (pos_ok) rd_r <= rd_word;
          else begin
            status_r <= alt_pkg::ST_RANGE;
            rd_r <= '1;
          end
        alt_pkg::KIND_SET:
          if (!pos_ok) status_r <= alt_pkg::ST_RANGE;
        default: status_r <= alt_pkg::ST_DONE;
      endcase
    end else if (state_r == alt_pkg::FSM_SEARCH) begin
      if (lo_r > hi_r) status_r <= alt_pkg::ST_NOT_FOUND;
      else if (x_r == rd_word) fidx_r <= mid;
      else if ($signed(x_r) < $signed(rd_word)) hi_r <= $signed({2'b00, mid}) - 6'sd1;
      else lo_r <= $signed({2'b00, mid}) + 6'sd1;
    end else if (state_r == alt_pkg::FSM_STATS && sweep_more) begin
      idx_r <= idx_r + 5'd1;
      sum_r <= sum_r + 36'($signed(rd_word));
      if (idx_r == 5'd0 || $signed(rd_word) > $signed(mx_r)) mx_r <= rd_word;
      if (idx_r == 5'd0 || $signed(rd_word) < $signed(mn_r)) mn_r <= rd_word;
    end
    if (emit) out_data_r <= {1'b0, mn_r, mx_r, sum_r, len_r, fidx_r, rd_r, status_r};
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= 5'(D)) else $error("list length above depth");
  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r == $past(len_r)) || (len_r == $past(len_r) + 5'd1) ||
    (len_r == $past(len_r) - 5'd1)) else $error("length moved by more than one");
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (state_r != alt_pkg::FSM_IDLE)) else $error("idle right after a transfer");
  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == alt_pkg::FSM_SEARCH) |-> (lo_r <= hi_r + 6'sd1))
    else $error("search window crossed");
endmodule
`default_nettype wire

>>> verif/tb_array_list_table_unit.sv
// testbench for array_list_table_unit: directed and random ops checked against a predictor
// depends on alt_pkg and the array_list_table_unit rtl
`timescale 1ns / 1ps

class list_scoreboard;
  logic signed [31:0] words [16];
  int unsigned count;
  int unsigned cap_reg;
  logic [143:0] pending [$];
  int unsigned errors;

  function new();
    count = 0;
    cap_reg = 16;
    errors = 0;
  endfunction

  function void set_capacity(logic [4:0] c);
    cap_reg = c;
  endfunction

  // apply one operation and queue the result it should produce
  function void note_op(alt_pkg::kind_t k, logic [4:0] pos, logic signed [31:0] x);
    alt_pkg::status_t st;
    logic signed [31:0] rd;
    logic [3:0] fidx;
    int unsigned cap;
    int i;
    int lo;
    int hi;
    int mid;
    logic signed [35:0] sum;
    logic signed [31:0] mx;
    logic signed [31:0] mn;
    st = alt_pkg::ST_DONE;
    rd = 0;
    fidx = 0;
    cap = (cap_reg < 16) ? cap_reg : 16;
    case (k)
      alt_pkg::KIND_APPEND: begin
        if (count >= cap) st = alt_pkg::ST_FULL;
        else begin
          words[count] = x;
          count++;
        end
      end
      alt_pkg::KIND_INSERT: begin
        if (pos > count) st = alt_pkg::ST_RANGE;
        else if (count >= cap) st = alt_pkg::ST_FULL;
        else begin
          for (i = count; i > pos; i--) words[i] = words[i-1];
          words[pos] = x;
          count++;
        end
      end
      alt_pkg::KIND_DELETE: begin
        if (pos >= count) st = alt_pkg::ST_RANGE;
        else begin
          rd = words[pos];
          for (i = pos; i + 1 < count; i++) words[i] = words[i+1];
          count--;
        end
      end
      alt_pkg::KIND_GET: begin
        if (pos >= count) begin
          st = alt_pkg::ST_RANGE;
          rd = -1;
        end else rd = words[pos];
      end
      alt_pkg::KIND_SET: begin
        if (pos >= count) st = alt_pkg::ST_RANGE;
        else words[pos] = x;
      end
      alt_pkg::KIND_SORTED: begin
        if (count >= cap) st = alt_pkg::ST_FULL;
        else begin
          i = count;
          while (i > 0 && x < words[i-1]) begin
            words[i] = words[i-1];
            i--;
          end
          words[i] = x;
          count++;
        end
      end
      alt_pkg::KIND_SEARCH: begin
        lo = 0;
        hi = int'(count) - 1;
        st = alt_pkg::ST_NOT_FOUND;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          if (x == words[mid]) begin
            st = alt_pkg::ST_DONE;
            fidx = mid[3:0];
            break;
          end else if (x < words[mid]) hi = mid - 1;
          else lo = mid + 1;
        end
      end
      default: ;
    endcase
    sum = 0;
    mx = 0;
    mn = 0;
    for (i = 0; i < count; i++) begin
      sum += 36'(words[i]);
      if (i == 0 || words[i] > mx) mx = words[i];
      if (i == 0 || words[i] < mn) mn = words[i];
    end
    pending.push_back({mn, mx, sum, 5'(count), fidx, rd, st});
  endfunction

  function void check_result(logic [143:0] got);
    logic [143:0] want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result transfer %h", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch st %0d/%0d rd %0d/%0d idx %0d/%0d cnt %0d/%0d",
                 want[1:0], got[1:0], $signed(want[33:2]), $signed(got[33:2]),
                 want[37:34], got[37:34], want[42:38], got[42:38]);
        $display("  sum %0d/%0d max %0d/%0d min %0d/%0d",
                 $signed(want[78:43]), $signed(got[78:43]), $signed(want[110:79]),
                 $signed(got[110:79]), $signed(want[142:111]), $signed(got[142:111]));
      end
    end
  endfunction
endclass

module tb_array_list_table_unit;
  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [2:0] in_tuser;
  logic [39:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [143:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [4:0] cfg_data;

  list_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  longint cycles;

  array_list_table_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: check on the rising edge, change ready at the falling edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // valid stays up after a transfer so the next item can follow at once
  task automatic send_op(alt_pkg::kind_t k, logic [4:0] pos, logic signed [31:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= k;
    in_tdata <= {3'b0, x, pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_op(k, pos, x);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_capacity(logic [4:0] c);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_capacity(c);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(20))) - 10;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic random_ops(int n);
    int j;
    alt_pkg::kind_t k;
    logic [4:0] pos;
    for (j = 0; j < n; j++) begin
      k = alt_pkg::kind_t'($urandom_range(7));
      // mostly in range, sometimes anywhere
      pos = ($urandom_range(4) == 0) ? 5'($urandom()) : 5'($urandom_range(sb.count));
      // searches on a non-empty list use a stored key half the time
      if (k == alt_pkg::KIND_SEARCH && sb.count > 0 && $urandom_range(1))
        send_op(k, pos, sb.words[$urandom_range(sb.count - 1)]);
      else
        send_op(k, pos, pick_word());
    end
  endtask

  initial begin
    int ph;
    int d;
    sb = new();
    cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty list cases, extremes, every kind
    send_op(alt_pkg::KIND_GET, 5'd0, 0);
    send_op(alt_pkg::KIND_DELETE, 5'd31, 0);
    send_op(alt_pkg::KIND_SEARCH, 5'd0, 5);
    send_op(alt_pkg::KIND_INSERT, 5'd1, 7);
    send_op(alt_pkg::KIND_APPEND, 5'd0, 32'sh7fffffff);
    send_op(alt_pkg::KIND_APPEND, 5'd0, 32'sh80000000);
    send_op(alt_pkg::KIND_INSERT, 5'd1, -1);
    send_op(alt_pkg::KIND_SET, 5'd2, 32'sh7fffffff);
    send_op(alt_pkg::KIND_GET, 5'd2, 0);
    send_op(alt_pkg::KIND_SET, 5'd3, 1);
    send_op(alt_pkg::KIND_DELETE, 5'd0, 0);
    send_op(alt_pkg::KIND_NOP, 5'd31, -1);
    for (d = 0; d < 14; d++) send_op(alt_pkg::KIND_APPEND, 5'd0, 32'sh7fffffff);
    send_op(alt_pkg::KIND_INSERT, 5'd0, 3);
    send_op(alt_pkg::KIND_SEARCH, 5'd0, 32'sh7fffffff);

    write_capacity(5'd0);
    send_op(alt_pkg::KIND_SORTED, 5'd0, 1);
    for (d = 0; d < 16; d++) send_op(alt_pkg::KIND_DELETE, 5'd0, 0);
    send_op(alt_pkg::KIND_APPEND, 5'd0, 1);
    write_capacity(5'd31);

    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      write_capacity(5'($urandom_range(1) ? 16 : $urandom_range(31)));
      // sorted fill then searches
      while (sb.count > 0) send_op(alt_pkg::KIND_DELETE, 5'd0, 0);
      for (d = 0; d < 10; d++) send_op(alt_pkg::KIND_SORTED, 5'd0, pick_word());
      for (d = 0; d < 15; d++)
        send_op(alt_pkg::KIND_SEARCH, 5'd0,
                (d % 2) ? sb.words[$urandom_range(9)] : pick_word());
      random_ops(105);
    end
    write_capacity(5'd16);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
